@@ hdl/gpdc_pkg.sv @@
// Shared types and constants of the gradient-predict delta coder.
package gpdc_pkg;

   localparam int MAX_TILE_WIDTH = 256;
   localparam int SAMPLE_W       = 8;
   localparam int ADDR_W         = $clog2(MAX_TILE_WIDTH);
   localparam int COL_W          = $clog2(MAX_TILE_WIDTH + 1);

   localparam logic [SAMPLE_W-1:0] CODE_BIAS = 8'd128;

   // Pipeline moves decided at the top level.
   typedef struct packed {
      logic accept;    // input beat taken this cycle
      logic advance;   // slot register moves into the result register
   } gpdc_ctrl_type;

   // One accepted sample with its position, waiting for the line-store data.
   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                tile_start;
      logic                first_row;
      logic                col_zero;
      logic                overflow;
   } gpdc_slot_type;

   // Line-store access issued at accept time.
   typedef struct packed {
      logic                rd_en;
      logic                wr_en;
      logic [ADDR_W-1:0]   addr;
      logic [SAMPLE_W-1:0] wr_data;
   } gpdc_lookup_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] coded_byte;
      logic [SAMPLE_W-1:0] residual_value;
      logic                width_error;
   } gpdc_result_type;

endpackage

@@ hdl/gpdc_req_if.sv @@
// Input channel: one sample beat with its tile and row flags.
interface gpdc_req_if;
   import gpdc_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       first_in_tile;
   logic                       first_in_row;

   modport source (output valid, output sample, output first_in_tile,
                   output first_in_row, input ready);
   modport sink   (input valid, input sample, input first_in_tile,
                   input first_in_row, output ready);
endinterface

@@ hdl/gpdc_rsp_if.sv @@
// Result channel: coded byte, residual and width flag of one sample.
interface gpdc_rsp_if;
   import gpdc_pkg::*;

   logic                       valid;
   logic                       ready;
   logic        [SAMPLE_W-1:0] coded_byte;
   logic signed [SAMPLE_W-1:0] residual_value;
   logic                       width_error;

   modport source (output valid, output coded_byte, output residual_value,
                   output width_error, input ready);
   modport sink   (input valid, input coded_byte, input residual_value,
                   input width_error, output ready);
endinterface

@@ hdl/gpdc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module gpdc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old word on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/gpdc_track.sv @@
// Column and first-row tracking, line-store access and the slot register.
module gpdc_track (
   input  logic                      clock,
   input  logic                      reset,
   input  gpdc_pkg::gpdc_ctrl_type   ctrl,
   input  logic [7:0]                in_sample,
   input  logic                      in_first_in_tile,
   input  logic                      in_first_in_row,
   output gpdc_pkg::gpdc_lookup_type lookup,
   output gpdc_pkg::gpdc_slot_type   slot,
   output logic                      slot_valid
);
   import gpdc_pkg::*;

   logic [COL_W-1:0] col_ff, col_in;
   logic             first_row_ff, first_row_in;
   logic             slot_valid_ff, slot_valid_in;
   gpdc_slot_type    slot_ff, slot_in;

   logic [COL_W-1:0] cur_col;
   logic             cur_first_row;
   logic             cur_overflow;

   // tile start wins over row start
   always_comb begin
      priority if (in_first_in_tile) begin
         cur_col       = '0;
         cur_first_row = 1'b1;
      end else if (in_first_in_row) begin
         cur_col       = '0;
         cur_first_row = 1'b0;
      end else begin
         cur_col       = col_ff;
         cur_first_row = first_row_ff;
      end
   end

   assign cur_overflow = (cur_col >= COL_W'(MAX_TILE_WIDTH));

   always_comb begin
      col_in        = col_ff;
      first_row_in  = first_row_ff;
      slot_in       = slot_ff;
      slot_valid_in = slot_valid_ff;
      if (ctrl.advance) begin
         slot_valid_in = 1'b0;
      end
      if (ctrl.accept) begin
         col_in             = cur_overflow ? COL_W'(MAX_TILE_WIDTH) : cur_col + 1'b1;
         first_row_in       = cur_first_row;
         slot_in.sample     = in_sample;
         slot_in.tile_start = in_first_in_tile;
         slot_in.first_row  = cur_first_row;
         slot_in.col_zero   = (cur_col == '0);
         slot_in.overflow   = cur_overflow;
         slot_valid_in      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         first_row_ff  <= 1'b1;
         slot_valid_ff <= 1'b0;
      end else begin
         col_ff        <= col_in;
         first_row_ff  <= first_row_in;
         slot_valid_ff <= slot_valid_in;
      end
      slot_ff <= slot_in;
   end

   // read the top neighbor and store this sample in the same beat
   assign lookup.rd_en   = ctrl.accept;
   assign lookup.wr_en   = ctrl.accept && !cur_overflow;
   assign lookup.addr    = cur_col[ADDR_W-1:0];
   assign lookup.wr_data = in_sample;

   assign slot       = slot_ff;
   assign slot_valid = slot_valid_ff;

   a_reset_state: assert property (@(posedge clock)
      reset |=> (col_ff == '0) && first_row_ff && !slot_valid_ff)
      else $error("track state not cleared by reset");

   a_col_saturates: assert property (@(posedge clock) disable iff (reset)
      (ctrl.accept && cur_overflow) |=> (col_ff == COL_W'(MAX_TILE_WIDTH)))
      else $error("column count did not saturate on overflow");

   a_col_bounded: assert property (@(posedge clock) disable iff (reset)
      col_ff <= COL_W'(MAX_TILE_WIDTH))
      else $error("column count beyond line store depth");

   a_advance_needs_slot: assert property (@(posedge clock) disable iff (reset)
      ctrl.advance |-> slot_valid_ff)
      else $error("advance from an empty slot");

endmodule

@@ hdl/gpdc_predict.sv @@
// Gradient prediction, residual and delta coding into the result register.
module gpdc_predict (
   input  logic                      clock,
   input  logic                      reset,
   input  gpdc_pkg::gpdc_ctrl_type   ctrl,
   input  gpdc_pkg::gpdc_slot_type   slot,
   input  logic [7:0]                top_data,
   input  logic                      out_ready,
   output gpdc_pkg::gpdc_result_type result,
   output logic                      out_valid
);
   import gpdc_pkg::*;

   logic [SAMPLE_W-1:0] left_ff, left_in;
   logic [SAMPLE_W-1:0] top_left_ff, top_left_in;
   logic [SAMPLE_W-1:0] prev_res_ff, prev_res_in;
   logic                out_valid_ff, out_valid_in;
   gpdc_result_type     result_ff, result_in;

   logic [SAMPLE_W-1:0] top;
   logic [SAMPLE_W-1:0] pred;
   logic [SAMPLE_W-1:0] prev_res;
   logic [SAMPLE_W-1:0] res;

   assign top      = slot.overflow ? '0 : top_data;
   assign prev_res = slot.tile_start ? '0 : prev_res_ff;

   always_comb begin
      priority if (slot.first_row && slot.col_zero) begin
         pred = '0;
      end else if (slot.first_row) begin
         pred = left_ff;
      end else if (slot.col_zero) begin
         pred = top;
      end else begin
         pred = left_ff + top - top_left_ff;
      end
   end

   assign res = slot.sample - pred;

   always_comb begin
      left_in      = left_ff;
      top_left_in  = top_left_ff;
      prev_res_in  = prev_res_ff;
      result_in    = result_ff;
      out_valid_in = out_valid_ff;
      if (out_ready) begin
         out_valid_in = 1'b0;
      end
      if (ctrl.advance) begin
         left_in                  = slot.sample;
         top_left_in              = top;
         prev_res_in              = res;
         result_in.coded_byte     = res - prev_res + CODE_BIAS;
         result_in.residual_value = res;
         result_in.width_error    = slot.overflow;
         out_valid_in             = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff      <= '0;
         top_left_ff  <= '0;
         prev_res_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         left_ff      <= left_in;
         top_left_ff  <= top_left_in;
         prev_res_ff  <= prev_res_in;
         out_valid_ff <= out_valid_in;
      end
      result_ff <= result_in;
   end

   assign result    = result_ff;
   assign out_valid = out_valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl.advance |-> (!out_valid_ff || out_ready))
      else $error("result register overwritten while held");

   a_prev_tracks_out: assert property (@(posedge clock) disable iff (reset)
      ctrl.advance |=> (prev_res_ff == result_ff.residual_value))
      else $error("previous residual differs from last result");

   a_left_tracks_slot: assert property (@(posedge clock) disable iff (reset)
      ctrl.advance |=> (left_ff == $past(slot.sample)))
      else $error("left neighbor not taken from advanced sample");

endmodule

@@ hdl/gradient_predict_delta_coder.sv @@
// Top level of the gradient-predict delta coder.
//
// Usage:
//   req carries one signed 8-bit sample per beat in raster order, with
//   first_in_tile on the first sample of a tile and first_in_row on the first
//   sample of every later row. rsp returns one beat per sample: the coded byte
//   (residual delta plus 128, mod 256), the residual and width_error, which is
//   set for columns at or past the 256-entry line store.
//
// Timing:
//   An accepted sample is held in the slot register and then in the result
//   register, which rsp offers. One beat per cycle is sustained while rsp
//   does not stall; the line-store read is issued at accept and its
//   registered data meets the sample in the slot register, then one stage of
//   prediction logic fills the result register.
//
// Reset clears the column count, neighbor registers and all valid bits and
// sets the first-row flag; the line store is not cleared and needs no clearing
// pass. With rsp stalled the result and slot registers hold and req still takes
// one more beat into an empty slot, then drops ready until rsp takes a beat.
module gradient_predict_delta_coder (
   input logic     clock,
   input logic     reset,
   gpdc_req_if.sink   req,
   gpdc_rsp_if.source rsp
);
   import gpdc_pkg::*;

   gpdc_ctrl_type   ctrl;
   gpdc_lookup_type lookup;
   gpdc_slot_type   slot;
   gpdc_result_type result;
   logic            slot_valid;
   logic            out_valid;
   logic [SAMPLE_W-1:0] top_data;

   // slot moves on when the result register is free or being emptied
   assign ctrl.advance = slot_valid && (!out_valid || rsp.ready);
   assign req.ready    = !slot_valid || ctrl.advance;
   assign ctrl.accept  = req.valid && req.ready;

   gpdc_track u_track (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .in_sample        (req.sample),
      .in_first_in_tile (req.first_in_tile),
      .in_first_in_row  (req.first_in_row),
      .lookup           (lookup),
      .slot             (slot),
      .slot_valid       (slot_valid)
   );

   // previous-row samples
   gpdc_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_TILE_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (lookup.wr_en),
      .wr_addr (lookup.addr),
      .wr_data (lookup.wr_data),
      .rd_en   (lookup.rd_en),
      .rd_addr (lookup.addr),
      .rd_data (top_data)
   );

   gpdc_predict u_predict (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .slot      (slot),
      .top_data  (top_data),
      .out_ready (rsp.ready),
      .result    (result),
      .out_valid (out_valid)
   );

   assign rsp.valid          = out_valid;
   assign rsp.coded_byte     = result.coded_byte;
   assign rsp.residual_value = result.residual_value;
   assign rsp.width_error    = result.width_error;

   a_full_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (slot_valid && out_valid && !rsp.ready) |-> !req.ready)
      else $error("input taken with both stages full and output stalled");

   a_accept_fills_slot: assert property (@(posedge clock) disable iff (reset)
      ctrl.accept |=> slot_valid)
      else $error("accepted beat lost before slot register");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !slot_valid |-> req.ready)
      else $error("input stalled with empty slot");

endmodule
